### src/tsc_pkg.sv
`default_nettype none
package tsc_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ANGLE,
        S_ACC,
        S_MUL_LO,
        S_MUL_HI,
        S_LOAD,
        S_DIV,
        S_ABS,
        S_ROUND
    } t_state;

    // Commands
    localparam logic CMD_SINE   = 1'b0;
    localparam logic CMD_COSINE = 1'b1;

    // Term word: a chain of hex digit cells
    localparam int DIG_W = 4;
    localparam int NDIG  = 10;
    localparam int TW    = DIG_W * NDIG;
    localparam int CNT_W = 4;

    // Shared multiplier operand widths and accumulator width
    localparam int MA_W = TW / 2;
    localparam int MB_W = 27;
    localparam int MP_W = MA_W + MB_W;
    localparam int AW   = 64;

    // Sum, angle and config widths
    localparam int SW   = 42;
    localparam int AA_W = 16;
    localparam int CFG_W = 5;

    localparam logic [MB_W-1:0] DEG2RAD     = 27'd74961321;
    localparam logic signed [16:0] ANGLE_LIMIT = 17'sd46080;
    localparam logic [TW-1:0]   ONE_Q30     = TW'(64'h4000_0000);
    localparam logic [CFG_W-1:0] TERM_RESET = 5'd8;

endpackage
`default_nettype wire

### src/tsc_cell.sv
`default_nettype none
module tsc_cell (
    input  wire logic                    i_clk,
    input  wire logic                    i_load,
    input  wire logic                    i_shift,
    input  wire logic [tsc_pkg::DIG_W-1:0] i_load_digit,
    input  wire logic [tsc_pkg::DIG_W-1:0] i_prev_digit,
    output logic      [tsc_pkg::DIG_W-1:0] o_digit
);

    logic [tsc_pkg::DIG_W-1:0] r_digit;

    // Load a fresh digit or take the neighbor's digit
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_digit <= i_load_digit;
        end else if (i_shift) begin
            r_digit <= i_prev_digit;
        end
    end

    assign o_digit = r_digit;

endmodule
`default_nettype wire

### src/tsc_digit.sv
`default_nettype none
module tsc_digit #(
    parameter int KW = 6
) (
    input  wire logic [KW-1:0]               i_rem,
    input  wire logic [tsc_pkg::DIG_W-1:0]   i_digit,
    input  wire logic [KW-1:0]               i_div,
    output logic      [KW-1:0]               o_rem,
    output logic      [tsc_pkg::DIG_W-1:0]   o_quot
);

    // Four restoring division steps, one dividend bit each
    always_comb begin
        logic [KW:0] v_r;
        v_r = {1'b0, i_rem};
        o_quot = '0;
        for (int b = tsc_pkg::DIG_W - 1; b >= 0; b--) begin
            v_r = {v_r[KW-1:0], i_digit[b]};
            if (v_r >= {1'b0, i_div}) begin
                v_r = v_r - {1'b0, i_div};
                o_quot[b] = 1'b1;
            end
        end
        o_rem = v_r[KW-1:0];
    end

endmodule
`default_nettype wire

### src/taylor_sine_cosine.sv
// Channel   | Direction | Request moves
// s_axis    | in        | tuser[0] command, tdata[16:0] angle_deg
// m_axis    | out       | tdata[31:0] value, tuser[0] saturated
// cfg       | in        | i_cfg_data[4:0] term_count
//
// One item at a time; terms run up to order K, the highest order (2n-1 sine,
// 2n-2 cosine, n the clamped term count). Each order costs two shared
// multiplier passes, a load and ten digit steps through the divider chain.
// Reset (synchronous, active low) sets term_count to 8 and empties the output.
// A result waiting on m_axis does not block the next request on s_axis.
`default_nettype none
module taylor_sine_cosine #(
    parameter int MAX_TERMS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [16:0] angle_deg
    input  wire logic [0:0]  s_axis_tuser,   // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value
    output logic [0:0]       m_axis_tuser,   // [0] saturated
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [tsc_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int KW = $clog2(2 * MAX_TERMS);

    tsc_pkg::t_state r_state, n_state;
    logic [tsc_pkg::CFG_W-1:0] r_term;
    logic                  r_cmd, n_cmd;
    logic                  r_xneg, n_xneg;
    logic                  r_empty, n_empty;
    logic [tsc_pkg::AA_W-1:0] r_aa, n_aa;
    logic [tsc_pkg::MB_W-1:0] r_ax, n_ax;
    logic [KW-1:0]         r_order, n_order;
    logic [KW-1:0]         r_kmax, n_kmax;
    logic [tsc_pkg::AW-1:0] r_acc, n_acc;
    logic [KW-1:0]         r_rem, n_rem;
    logic [tsc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic signed [tsc_pkg::SW-1:0] r_sum, n_sum;
    logic [tsc_pkg::SW-1:0] r_smag, n_smag;
    logic                  r_sneg, n_sneg;
    logic                  r_out_valid, n_out_valid;
    logic [31:0]           r_value, n_value;
    logic                  r_sat, n_sat;

    logic [tsc_pkg::MA_W-1:0] w_mul_a;
    logic [tsc_pkg::MB_W-1:0] w_mul_b;
    logic [tsc_pkg::MP_W-1:0] w_mul_p;
    logic                  w_load, w_shift;
    logic [tsc_pkg::TW-1:0] w_load_word;
    logic [tsc_pkg::TW-1:0] w_t;
    logic [tsc_pkg::DIG_W-1:0] w_digit [tsc_pkg::NDIG];
    logic [tsc_pkg::DIG_W-1:0] w_qdig;
    logic [KW-1:0]         w_step_rem;

    // Shared multiplier: angle scaling, then the low and high halves of t*|x|
    always_comb begin
        case (r_state)
            tsc_pkg::S_ANGLE: begin
                w_mul_a = tsc_pkg::MA_W'(r_aa);
                w_mul_b = tsc_pkg::DEG2RAD;
            end
            tsc_pkg::S_MUL_HI: begin
                w_mul_a = w_t[tsc_pkg::TW-1:tsc_pkg::MA_W];
                w_mul_b = r_ax;
            end
            default: begin
                w_mul_a = w_t[tsc_pkg::MA_W-1:0];
                w_mul_b = r_ax;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // Digit cell chain holding the term; shifts up one digit per divide step
    for (genvar g = 0; g < tsc_pkg::NDIG; g++) begin : g_cell
        tsc_cell u_cell (
            .i_clk        (i_clk),
            .i_load       (w_load),
            .i_shift      (w_shift),
            .i_load_digit (w_load_word[g*tsc_pkg::DIG_W +: tsc_pkg::DIG_W]),
            .i_prev_digit ((g == 0) ? w_qdig : w_digit[(g == 0) ? 0 : g-1]),
            .o_digit      (w_digit[g])
        );
        assign w_t[g*tsc_pkg::DIG_W +: tsc_pkg::DIG_W] = w_digit[g];
    end

    tsc_digit #(.KW(KW)) u_digit (
        .i_rem   (r_rem),
        .i_digit (w_digit[tsc_pkg::NDIG-1]),
        .i_div   (r_order),
        .o_rem   (w_step_rem),
        .o_quot  (w_qdig)
    );

    // Sequencer: next state and datapath updates
    always_comb begin
        logic signed [16:0] v_ang;
        logic [KW-1:0]      v_n;
        logic [KW:0]        v_k;
        logic [tsc_pkg::MP_W-1:0] v_ax;
        logic               v_neg;
        logic signed [tsc_pkg::SW-1:0] v_t;
        logic [tsc_pkg::SW:0] v_q;
        logic [32:0]        v_qc;
        logic [32:0]        v_res;

        n_state = r_state;
        n_cmd = r_cmd; n_xneg = r_xneg; n_empty = r_empty; n_aa = r_aa;
        n_ax = r_ax; n_order = r_order; n_kmax = r_kmax; n_acc = r_acc;
        n_rem = r_rem; n_cnt = r_cnt; n_sum = r_sum; n_smag = r_smag;
        n_sneg = r_sneg; n_value = r_value; n_sat = r_sat;
        n_out_valid = r_out_valid & ~m_axis_tready;
        w_load = 1'b0;
        w_shift = 1'b0;
        w_load_word = tsc_pkg::ONE_Q30;
        v_ang = $signed(s_axis_tdata[16:0]);
        v_n = '0;
        v_k = '0;
        v_ax = w_mul_p + tsc_pkg::MP_W'(1 << 14);
        v_neg = r_order[1] ^ (~r_cmd & r_xneg);
        v_t = $signed(tsc_pkg::SW'(w_t));
        v_q = ({1'b0, r_smag} + (tsc_pkg::SW+1)'(32)) >> 6;
        v_qc = '0;
        v_res = '0;

        case (r_state)
            tsc_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    // Clamp the angle and split off its sign
                    if (v_ang > tsc_pkg::ANGLE_LIMIT) v_ang = tsc_pkg::ANGLE_LIMIT;
                    if (v_ang < -tsc_pkg::ANGLE_LIMIT) v_ang = -tsc_pkg::ANGLE_LIMIT;
                    n_cmd = s_axis_tuser[0];
                    n_xneg = v_ang[16];
                    n_aa = v_ang[16] ? tsc_pkg::AA_W'(-v_ang) : tsc_pkg::AA_W'(v_ang);
                    if (32'(r_term) > 32'(MAX_TERMS)) v_n = KW'(MAX_TERMS);
                    else v_n = KW'(r_term);
                    n_empty = (v_n == '0);
                    v_k = {v_n, 1'b0} - ((s_axis_tuser[0] == tsc_pkg::CMD_COSINE)
                                         ? (KW+1)'(2) : (KW+1)'(1));
                    n_kmax = v_k[KW-1:0];
                    n_state = tsc_pkg::S_ANGLE;
                end
            end
            tsc_pkg::S_ANGLE: begin
                n_ax = v_ax[tsc_pkg::MB_W+14:15];
                n_order = '0;
                n_sum = '0;
                w_load = 1'b1;
                w_load_word = tsc_pkg::ONE_Q30;
                n_state = r_empty ? tsc_pkg::S_ABS : tsc_pkg::S_ACC;
            end
            tsc_pkg::S_ACC: begin
                // Add or subtract the term, by its sign, when its order belongs to the selected series
                if (r_order[0] != r_cmd) begin
                    n_sum = v_neg ? r_sum - v_t : r_sum + v_t;
                end
                if (r_order == r_kmax) begin
                    n_state = tsc_pkg::S_ABS;
                end else begin
                    n_order = r_order + KW'(1);
                    n_state = tsc_pkg::S_MUL_LO;
                end
            end
            tsc_pkg::S_MUL_LO: begin
                n_acc = tsc_pkg::AW'(w_mul_p) + tsc_pkg::AW'(1 << 23);
                n_state = tsc_pkg::S_MUL_HI;
            end
            tsc_pkg::S_MUL_HI: begin
                n_acc = r_acc + tsc_pkg::AW'({w_mul_p, {tsc_pkg::MA_W{1'b0}}});
                n_state = tsc_pkg::S_LOAD;
            end
            tsc_pkg::S_LOAD: begin
                // Round the product and pre-add half the divisor
                w_load = 1'b1;
                w_load_word = r_acc[tsc_pkg::AW-1:24] + tsc_pkg::TW'(r_order >> 1);
                n_rem = '0;
                n_cnt = '0;
                n_state = tsc_pkg::S_DIV;
            end
            tsc_pkg::S_DIV: begin
                w_shift = 1'b1;
                n_rem = w_step_rem;
                n_cnt = r_cnt + tsc_pkg::CNT_W'(1);
                if (r_cnt == tsc_pkg::CNT_W'(tsc_pkg::NDIG - 1)) n_state = tsc_pkg::S_ACC;
            end
            tsc_pkg::S_ABS: begin
                n_sneg = r_sum[tsc_pkg::SW-1];
                n_smag = r_sum[tsc_pkg::SW-1] ? tsc_pkg::SW'(-r_sum) : tsc_pkg::SW'(r_sum);
                n_state = tsc_pkg::S_ROUND;
            end
            tsc_pkg::S_ROUND: begin
                // Round to Q7.24, clamp, and hand off once the output is free
                if (!r_out_valid || m_axis_tready) begin
                    if (r_sneg && v_q > (tsc_pkg::SW+1)'(64'h8000_0000)) begin
                        v_qc = 33'h1_0000_0000 >> 1;
                        n_sat = 1'b1;
                    end else if (!r_sneg && v_q > (tsc_pkg::SW+1)'(64'h7FFF_FFFF)) begin
                        v_qc = 33'h0_7FFF_FFFF;
                        n_sat = 1'b1;
                    end else begin
                        v_qc = v_q[32:0];
                        n_sat = 1'b0;
                    end
                    v_res = r_sneg ? -v_qc : v_qc;
                    n_value = v_res[31:0];
                    n_out_valid = 1'b1;
                    n_state = tsc_pkg::S_IDLE;
                end
            end
            default: n_state = tsc_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsc_pkg::S_IDLE;
            r_term <= tsc_pkg::TERM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) r_term <= i_cfg_data;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_xneg <= n_xneg; r_empty <= n_empty; r_aa <= n_aa;
        r_ax <= n_ax; r_order <= n_order; r_kmax <= n_kmax; r_acc <= n_acc;
        r_rem <= n_rem; r_cnt <= n_cnt; r_sum <= n_sum; r_smag <= n_smag;
        r_sneg <= n_sneg; r_value <= n_value; r_sat <= n_sat;
    end

    assign s_axis_tready = (r_state == tsc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_value;
    assign m_axis_tuser = r_sat;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsc_pkg::S_DIV) |-> (r_order != '0))
        else $error("divide step with zero divisor");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsc_pkg::S_DIV) |-> (r_cnt < tsc_pkg::CNT_W'(tsc_pkg::NDIG)))
        else $error("divide step count overrun");
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == tsc_pkg::S_ANGLE))
        else $error("accepted request did not start");
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000))
        else $error("saturated flag without clamped value");
    a_order_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsc_pkg::S_MUL_LO) |-> (r_order <= r_kmax))
        else $error("order past last term");
`endif

endmodule
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANGLE_MAX     = 46080;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int LONG_HOLD     = 1500;

    typedef struct {
        logic [31:0] value;
        logic        saturated;
    } t_trig_result;

    typedef struct {
        logic [4:0]         terms;
        logic               cmd;
        logic signed [16:0] angle;
        bit                 typed;
        logic [31:0]        value;
        logic               saturated;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [16:0] angle_deg
    logic [0:0]  s_axis_tuser = '0;    // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] value
    logic [0:0]  m_axis_tuser;         // [0] saturated
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [tsc_pkg::CFG_W-1:0] i_cfg_data = '0;

    t_trig_result pending_results[$];
    logic [4:0]   model_terms = tsc_pkg::TERM_RESET;
    int  fail_count = 0;
    int  sent_count = 0;
    int  checked_count = 0;
    int  sat_count = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  no_idle = 1'b0;

    taylor_sine_cosine i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Partial Taylor sum in fixed point, one term per loop pass
    function automatic t_trig_result taylor_eval(logic cmd, logic signed [16:0] ang,
                                                 logic [4:0] terms);
        longint a;
        longint unsigned aa, ax, mag, order, k, p, smag, q;
        longint sum;
        int n;
        bit xneg, neg;
        t_trig_result r;
        a = ang;
        if (a > ANGLE_MAX) a = ANGLE_MAX;
        if (a < -ANGLE_MAX) a = -ANGLE_MAX;
        xneg = a < 0;
        aa = xneg ? -a : a;
        ax = (aa * 64'(tsc_pkg::DEG2RAD) + 64'd16384) >> 15;
        n = (terms > 16) ? 16 : terms;
        mag = 64'd1 << 30;
        order = 0;
        sum = 0;
        for (int i = 1; i <= n; i++) begin
            k = (cmd == tsc_pkg::CMD_COSINE) ? 2 * i - 2 : 2 * i - 1;
            while (order < k) begin
                order++;
                p = (mag * ax + (64'd1 << 23)) >> 24;
                mag = (p + (order >> 1)) / order;
            end
            neg = (i % 2) == 0;
            if (cmd == tsc_pkg::CMD_SINE && xneg) neg = !neg;
            if (neg) sum -= longint'(mag);
            else sum += longint'(mag);
        end
        smag = (sum < 0) ? -sum : sum;
        q = (smag + 64'd32) >> 6;
        r.saturated = 1'b0;
        if (sum < 0) begin
            if (q > 64'd2147483648) begin
                q = 64'd2147483648;
                r.saturated = 1'b1;
            end
            r.value = 32'(-longint'(q));
        end else begin
            if (q > 64'd2147483647) begin
                q = 64'd2147483647;
                r.saturated = 1'b1;
            end
            r.value = 32'(q);
        end
        return r;
    endfunction

    // Hold until every result is back, then let the block settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_terms(logic [4:0] terms);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= terms;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_terms = terms;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one request; valid stays high into the next call unless idling
    task automatic send_request(logic cmd, logic signed [16:0] ang, bit typed,
                                t_trig_result typed_res);
        if (!no_idle && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, ang};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(typed ? typed_res : taylor_eval(cmd, ang, model_terms));
        sent_count++;
        @(negedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    // Check results, watch for a hung block
    always @(posedge i_clk) begin
        t_trig_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result value=%0d", $signed(m_axis_tdata));
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tdata !== exp_res.value) begin
                    $error("value: expected %0d, got %0d",
                           $signed(exp_res.value), $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tuser[0] !== exp_res.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           exp_res.saturated, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tuser[0] === 1'b1) sat_count++;
                checked_count++;
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("taylor_sine_cosine verification failed");
            $finish;
        end
    end

    initial begin
        t_stim_row rows[$];
        t_trig_result tr;
        logic [4:0] phase_terms[7] = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd0, 5'd3, 5'd8};
        logic signed [16:0] ang;
        logic cmd;

        // Directed: extremes, both commands, clamping, zero and excess term counts
        rows = '{
            '{5'd8,  tsc_pkg::CMD_SINE,   17'sd0,      1'b1, 32'd0,        1'b0},
            '{5'd8,  tsc_pkg::CMD_COSINE, 17'sd0,      1'b1, 32'd16777216, 1'b0},
            '{5'd8,  tsc_pkg::CMD_SINE,   17'sd46080,  1'b0, 32'd0, 1'b0},
            '{5'd8,  tsc_pkg::CMD_COSINE, -17'sd46080, 1'b0, 32'd0, 1'b0},
            '{5'd8,  tsc_pkg::CMD_SINE,   17'sd65535,  1'b0, 32'd0, 1'b0},
            '{5'd8,  tsc_pkg::CMD_COSINE, -17'sd65536, 1'b0, 32'd0, 1'b0},
            '{5'd8,  tsc_pkg::CMD_SINE,   -17'sd11520, 1'b0, 32'd0, 1'b0},
            '{5'd8,  tsc_pkg::CMD_COSINE, 17'sd23040,  1'b0, 32'd0, 1'b0},
            '{5'd0,  tsc_pkg::CMD_SINE,   17'sd46080,  1'b1, 32'd0,        1'b0},
            '{5'd0,  tsc_pkg::CMD_COSINE, -17'sd12345, 1'b1, 32'd0,        1'b0},
            '{5'd1,  tsc_pkg::CMD_COSINE, 17'sd46080,  1'b1, 32'd16777216, 1'b0},
            '{5'd1,  tsc_pkg::CMD_SINE,   -17'sd46080, 1'b0, 32'd0, 1'b0},
            '{5'd16, tsc_pkg::CMD_SINE,   17'sd46080,  1'b0, 32'd0, 1'b0},
            '{5'd16, tsc_pkg::CMD_COSINE, -17'sd46080, 1'b0, 32'd0, 1'b0},
            '{5'd31, tsc_pkg::CMD_SINE,   -17'sd65536, 1'b0, 32'd0, 1'b0},
            '{5'd31, tsc_pkg::CMD_COSINE, 17'sd1,      1'b0, 32'd0, 1'b0},
            '{5'd3,  tsc_pkg::CMD_SINE,   17'sd46080,  1'b0, 32'd0, 1'b0},
            '{5'd4,  tsc_pkg::CMD_COSINE, 17'sd46080,  1'b0, 32'd0, 1'b0},
            '{5'd4,  tsc_pkg::CMD_SINE,   -17'sd1,     1'b0, 32'd0, 1'b0}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].terms != model_terms) write_terms(rows[i].terms);
            tr.value = rows[i].value;
            tr.saturated = rows[i].saturated;
            send_request(rows[i].cmd, rows[i].angle, rows[i].typed, tr);
        end

        // Random phases over several term counts
        foreach (phase_terms[p]) begin
            write_terms(phase_terms[p]);
            no_idle = (p == 2);
            if (p == 1) hold_left = LONG_HOLD;
            for (int j = 0; j < RANDOM_ITEMS / 7; j++) begin
                cmd = $urandom_range(1);
                if ($urandom_range(4) == 0)
                    ang = 17'($urandom);
                else
                    ang = 17'($signed($urandom_range(2 * ANGLE_MAX)) - ANGLE_MAX);
                send_request(cmd, ang, 1'b0, tr);
                // Pause the sender until everything is back
                if (p == 4 && j == 50) wait_drained();
            end
        end

        wait_drained();
        repeat (500) @(negedge i_clk);
        $display("ran %0d requests over term counts 0..31, both functions, %0d checked,",
                 sent_count, checked_count);
        $display("%0d saturated results, with long output hold and drained pauses", sat_count);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("taylor_sine_cosine verification clean");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d results never arrived", pending_results.size());
            $display("taylor_sine_cosine verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
src/tsc_pkg.sv
src/tsc_cell.sv
src/tsc_digit.sv
src/taylor_sine_cosine.sv
tb/sv/tb.sv
